// ===== hw/rtl/sqosc_pkg.sv =====
// Shared types, constants and microcode program of the square-wave glide oscillator.
`timescale 1ns / 1ps
`default_nettype none

package sqosc_pkg;

   // field and state widths
   localparam int unsigned FREQ_IN_W  = 23;  // Hz, 8 fraction bits
   localparam int unsigned VOL_W      = 16;
   localparam int unsigned LEN_W      = 13;
   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned FREQ_W     = 40;  // Hz, 25 fraction bits
   localparam int unsigned STEP_W     = 41;  // signed glide step
   localparam int unsigned PPH_W      = 36;
   localparam int unsigned PPH_LO_W   = 18;
   localparam int unsigned PPH_HI_W   = PPH_W - PPH_LO_W;
   localparam int unsigned PROD_W     = 59;
   localparam int unsigned PART_W     = FREQ_IN_W + PPH_LO_W;
   localparam int unsigned FREQ_SHIFT = FREQ_W - FREQ_IN_W;
   localparam int unsigned DIV_CNT_W  = 6;
   localparam int unsigned LEN_MAX    = 8191;

   localparam logic [PPH_W-1:0]   PPH_RESET  = 36'd5864062014;
   localparam logic [VOL_W-1:0]   VOL_FULL   = 16'd32768;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'(FREQ_W - 1);

   // microcode step addresses
   localparam int unsigned PC_W = 4;
   localparam logic [PC_W-1:0] PC_FETCH     = 4'd0;
   localparam logic [PC_W-1:0] PC_MODE      = 4'd1;
   localparam logic [PC_W-1:0] PC_FIRST     = 4'd2;
   localparam logic [PC_W-1:0] PC_DIV_LOAD  = 4'd3;
   localparam logic [PC_W-1:0] PC_DIV_STEP  = 4'd4;
   localparam logic [PC_W-1:0] PC_GLIDE_SET = 4'd5;
   localparam logic [PC_W-1:0] PC_GLIDE_CHK = 4'd6;
   localparam logic [PC_W-1:0] PC_FREQ_ADD  = 4'd7;
   localparam logic [PC_W-1:0] PC_DIRECT    = 4'd8;
   localparam logic [PC_W-1:0] PC_MUL_PART  = 4'd9;
   localparam logic [PC_W-1:0] PC_MUL_SUM   = 4'd10;
   localparam logic [PC_W-1:0] PC_WAIT_OUT  = 4'd11;
   localparam logic [PC_W-1:0] PC_EMIT      = 4'd12;
   localparam logic [PC_W-1:0] PC_STOP      = 4'd13;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_FETCH,
      OP_DIV_LOAD,
      OP_DIV_STEP,
      OP_GLIDE_SET,
      OP_FREQ_ADD,
      OP_DIRECT,
      OP_MUL_PART,
      OP_MUL_SUM,
      OP_EMIT,
      OP_STOP
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_DIRECT,
      C_NOT_FIRST,
      C_SAME_TARGET,
      C_DIV_MORE,
      C_NOT_GLIDING,
      C_RSP_FULL
   } cond_type;

   typedef struct packed {
      op_type           op;
      cond_type         cond;
      logic [PC_W-1:0]  target;
   } ctrl_word_type;

   // program ROM: jump to target when cond holds, else fall through
   function automatic ctrl_word_type ucode(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = '{op: OP_NOP, cond: C_ALWAYS, target: PC_FETCH};
      unique case (pc)
         PC_FETCH:     w = '{op: OP_FETCH,     cond: C_NO_REQ,      target: PC_FETCH};
         PC_MODE:      w = '{op: OP_NOP,       cond: C_DIRECT,      target: PC_DIRECT};
         PC_FIRST:     w = '{op: OP_NOP,       cond: C_NOT_FIRST,   target: PC_GLIDE_CHK};
         PC_DIV_LOAD:  w = '{op: OP_DIV_LOAD,  cond: C_SAME_TARGET, target: PC_STOP};
         PC_DIV_STEP:  w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE,    target: PC_DIV_STEP};
         PC_GLIDE_SET: w = '{op: OP_GLIDE_SET, cond: C_NEVER,       target: PC_FETCH};
         PC_GLIDE_CHK: w = '{op: OP_NOP,       cond: C_NOT_GLIDING, target: PC_WAIT_OUT};
         PC_FREQ_ADD:  w = '{op: OP_FREQ_ADD,  cond: C_ALWAYS,      target: PC_MUL_PART};
         PC_DIRECT:    w = '{op: OP_DIRECT,    cond: C_NEVER,       target: PC_FETCH};
         PC_MUL_PART:  w = '{op: OP_MUL_PART,  cond: C_NEVER,       target: PC_FETCH};
         PC_MUL_SUM:   w = '{op: OP_MUL_SUM,   cond: C_NEVER,       target: PC_FETCH};
         PC_WAIT_OUT:  w = '{op: OP_NOP,       cond: C_RSP_FULL,    target: PC_WAIT_OUT};
         PC_EMIT:      w = '{op: OP_EMIT,      cond: C_ALWAYS,      target: PC_FETCH};
         PC_STOP:      w = '{op: OP_STOP,      cond: C_ALWAYS,      target: PC_WAIT_OUT};
         default:      w = '{op: OP_NOP,       cond: C_ALWAYS,      target: PC_FETCH};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/square_wave_oscillator_glide_unit.sv =====
// Square-wave oscillator with phase accumulator and linear glide, microcoded top level.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake             | Word contents
// ---------+-----------+-----------------------+----------------------------------------
// req      | in        | req_valid / req_ready | mode, frequency, volume, block_length,
//          |           |                       | first_in_block
// rsp      | out       | rsp_valid / rsp_ready | sample (signed Q1.15)
// csr      | in        | csr_we (no wait)      | phase_per_hz
//
// One word at a time, run by a 14-step microprogram. Each word starts at fetch and
// ends with emit; direct mode and glide samples recompute the phase increment, and a
// block start that sets a new glide first runs the restoring divider (one quotient
// bit per cycle, 40 bits). Synchronous reset returns control and architectural state
// to zero and phase_per_hz to 48 kHz scaling; payload and scratch are not reset.
// The output register frees the sequencer: it only stalls, at the step before emit,
// while a previous sample is still waiting on rsp_ready.

module square_wave_oscillator_glide_unit
   import sqosc_pkg::*;
#(
   parameter int unsigned MAX_BLOCK  = 4096,
   parameter int unsigned PHASE_BITS = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire                          req_mode,
   input  wire         [FREQ_IN_W-1:0]  req_frequency,
   input  wire         [VOL_W-1:0]      req_volume,
   input  wire         [LEN_W-1:0]      req_block_length,
   input  wire                          req_first_in_block,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic signed [SAMPLE_W-1:0]   rsp_sample,
   input  wire                          csr_we,
   input  wire         [PPH_W-1:0]      csr_wdata
);

   // effective block cap: the length field cannot exceed LEN_MAX anyway
   localparam int unsigned LEN_CAP   = (MAX_BLOCK > LEN_MAX) ? LEN_MAX : MAX_BLOCK;
   localparam int unsigned SL_W      = $clog2(LEN_CAP + 1);
   localparam int unsigned INC_SHIFT = 56 - PHASE_BITS;

   // sequencer
   logic [PC_W-1:0]        pc_ff, pc_in;
   ctrl_word_type          cw;
   logic                   cond_hit;

   // architectural state
   logic [PPH_W-1:0]       pph_ff, pph_in;
   logic [PHASE_BITS-1:0]  phase_ff, phase_in;
   logic [FREQ_W-1:0]      cur_ff, cur_in;
   logic [PHASE_BITS-1:0]  inc_ff, inc_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [SL_W-1:0]        left_ff, left_in;
   logic                   gliding_ff, gliding_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]    sample_ff, sample_in;

   // latched request word and scratch datapath
   logic                   mode_ff, mode_in;
   logic [FREQ_IN_W-1:0]   freq_ff, freq_in;
   logic [VOL_W-1:0]       vol_ff, vol_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic                   first_ff, first_in;
   logic [LEN_W-1:0]       den_ff, den_in;       // saturated block length
   logic                   up_ff, up_in;
   logic [FREQ_W-1:0]      quo_ff, quo_in;       // dividend shifts out, quotient in
   logic [LEN_W-1:0]       rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PART_W-1:0]      plo_ff, plo_in;
   logic [PART_W-1:0]      phi_ff, phi_in;

   // combinational helpers
   logic [FREQ_W-1:0]      target;
   logic [LEN_W-1:0]       len_sat;
   logic [LEN_W:0]         rem_sh;
   logic [FREQ_W-1:0]      quo_sh;
   logic [FREQ_IN_W-1:0]   hz8;
   logic [PROD_W-1:0]      prod;
   logic [VOL_W-1:0]       vol_sat;
   logic [SL_W-1:0]        left_dec;

   assign cw        = ucode(pc_ff);
   assign target    = {freq_ff, FREQ_SHIFT'(0)};
   assign hz8       = cur_ff[FREQ_W-1 -: FREQ_IN_W];
   assign req_ready = (cw.op == OP_FETCH);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample = sample_ff;

   // zero length counts as one; long blocks clamp to the cap
   always_comb begin
      len_sat = len_ff;
      if (len_ff == '0) begin
         len_sat = LEN_W'(1);
      end else if (len_ff > LEN_W'(LEN_CAP)) begin
         len_sat = LEN_W'(LEN_CAP);
      end
   end

   assign rem_sh   = {rem_ff, quo_ff[FREQ_W-1]};
   assign quo_sh   = {quo_ff[FREQ_W-2:0], 1'b0};
   assign prod     = PROD_W'(plo_ff) + (PROD_W'(phi_ff) << PPH_LO_W);
   assign vol_sat  = (vol_ff > VOL_FULL) ? VOL_FULL : vol_ff;
   assign left_dec = (left_ff != '0) ? left_ff - SL_W'(1) : '0;

   // branch conditions
   always_comb begin
      case (cw.cond)
         C_NEVER:       cond_hit = 1'b0;
         C_ALWAYS:      cond_hit = 1'b1;
         C_NO_REQ:      cond_hit = !req_valid;
         C_DIRECT:      cond_hit = mode_ff;
         C_NOT_FIRST:   cond_hit = !first_ff;
         C_SAME_TARGET: cond_hit = (target == cur_ff);
         C_DIV_MORE:    cond_hit = (cnt_ff != '0);
         C_NOT_GLIDING: cond_hit = !gliding_ff;
         // held only while the waiting sample is not taken this cycle
         C_RSP_FULL:    cond_hit = rsp_valid_ff && !rsp_ready;
         default:       cond_hit = 1'b0;
      endcase
   end

   // datapath, decoded from the control word
   always_comb begin
      pc_in        = cond_hit ? cw.target : pc_ff + PC_W'(1);
      pph_in       = csr_we ? csr_wdata : pph_ff;
      phase_in     = phase_ff;
      cur_in       = cur_ff;
      inc_in       = inc_ff;
      step_in      = step_ff;
      left_in      = left_ff;
      gliding_in   = gliding_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      sample_in    = sample_ff;
      mode_in      = mode_ff;
      freq_in      = freq_ff;
      vol_in       = vol_ff;
      len_in       = len_ff;
      first_in     = first_ff;
      den_in       = den_ff;
      up_in        = up_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;

      unique case (cw.op)
         OP_NOP: begin
         end
         OP_FETCH: begin
            if (req_valid) begin
               mode_in  = req_mode;
               freq_in  = req_frequency;
               vol_in   = req_volume;
               len_in   = req_block_length;
               first_in = req_first_in_block;
            end
         end
         OP_DIV_LOAD: begin
            // magnitude of the frequency gap over the block length
            den_in = len_sat;
            up_in  = target > cur_ff;
            quo_in = (target > cur_ff) ? target - cur_ff : cur_ff - target;
            rem_in = '0;
            cnt_in = DIV_LAST;
         end
         OP_DIV_STEP: begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = LEN_W'(rem_sh - {1'b0, den_ff});
               quo_in = quo_sh | FREQ_W'(1);
            end else begin
               rem_in = rem_sh[LEN_W-1:0];
               quo_in = quo_sh;
            end
            cnt_in = cnt_ff - DIV_CNT_W'(1);
         end
         OP_GLIDE_SET: begin
            step_in    = up_ff ? {1'b0, quo_ff} : STEP_W'(0) - {1'b0, quo_ff};
            left_in    = SL_W'(den_ff);
            gliding_in = 1'b1;
         end
         OP_FREQ_ADD: begin
            // two's complement step, wrap modulo 2^40
            cur_in = cur_ff + step_ff[FREQ_W-1:0];
         end
         OP_DIRECT: begin
            cur_in     = target;
            gliding_in = 1'b0;
            left_in    = '0;
         end
         OP_MUL_PART: begin
            // 23 x 36 product split into two 23 x 18 halves
            plo_in = PART_W'(hz8) * PART_W'(pph_ff[PPH_LO_W-1:0]);
            phi_in = PART_W'(hz8) * PART_W'(pph_ff[PPH_W-1 -: PPH_HI_W]);
         end
         OP_MUL_SUM: begin
            inc_in = prod[INC_SHIFT +: PHASE_BITS];
         end
         OP_EMIT: begin
            sample_in    = phase_ff[PHASE_BITS-1] ? '0 : SAMPLE_W'(0) - vol_sat;
            rsp_valid_in = 1'b1;
            phase_in     = phase_ff + inc_ff;
            if (gliding_ff) begin
               left_in = left_dec;
               // end of block: snap to target, increment left as is
               if (left_dec == '0) begin
                  cur_in     = target;
                  gliding_in = 1'b0;
               end
            end
         end
         OP_STOP: begin
            gliding_in = 1'b0;
            left_in    = '0;
         end
         default: begin
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_FETCH;
         pph_ff       <= PPH_RESET;
         phase_ff     <= '0;
         cur_ff       <= '0;
         inc_ff       <= '0;
         step_ff      <= '0;
         left_ff      <= '0;
         gliding_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         pph_ff       <= pph_in;
         phase_ff     <= phase_in;
         cur_ff       <= cur_in;
         inc_ff       <= inc_in;
         step_ff      <= step_in;
         left_ff      <= left_in;
         gliding_ff   <= gliding_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and scratch registers
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      mode_ff   <= mode_in;
      freq_ff   <= freq_in;
      vol_ff    <= vol_in;
      len_ff    <= len_in;
      first_ff  <= first_in;
      den_ff    <= den_in;
      up_ff     <= up_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      plo_ff    <= plo_in;
      phi_ff    <= phi_in;
   end

endmodule

`default_nettype wire
